FILE: rtl/dmxut_pkg.sv
// Shared constants, codes and inter-module types for the DMX512 universe transmitter.
// No dependencies; used by dmxut_ctrl, dmxut_dp and the top level.
`timescale 1ns / 1ps

package dmxut_pkg;

  // Universe and transmitter sizing
  localparam int SLOT_COUNT    = 127;
  localparam int TX_FIFO_DEPTH = 16;
  localparam int RUN_LIMIT     = 16;
  localparam int RUN_MAX       = (TX_FIFO_DEPTH < RUN_LIMIT) ? TX_FIFO_DEPTH : RUN_LIMIT;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);      // slot memory address
  localparam int NSLOT_W = $clog2(SLOT_COUNT + 1);  // slot counter
  localparam int RUN_W   = $clog2(RUN_MAX + 1);     // bytes left in a run

  // Field widths
  localparam int CMD_W     = 2;
  localparam int ELAPSED_W = 13;
  localparam int SPACE_W   = 5;
  localparam int NUM_W     = 10;
  localparam int LEVEL_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int BASE_W    = NUM_W + 2;             // (num - 1) * 3

  localparam int TIMER_W   = 16;
  localparam int LIMIT_W   = 17;                    // SLOT_COUNT * 63 + 1023 fits

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int BREAK_W    = 10;
  localparam int SLOTT_W    = 6;
  localparam int TAIL_W     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_BREAK_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_TIME  = 2'd2;

  localparam logic [BREAK_W-1:0] BREAK_TIME_RST = 10'd150;
  localparam logic [SLOTT_W-1:0] SLOT_TIME_RST  = 6'd44;
  localparam logic [TAIL_W-1:0]  TAIL_TIME_RST  = 10'd100;

  localparam logic [BYTE_W-1:0] LEVEL_MAX  = 8'd255;
  localparam logic [BYTE_W-1:0] START_CODE = 8'd0;
  localparam logic [BYTE_W-1:0] BREAK_BYTE = 8'd0;

  // Line mode: break rate 83333 baud 8N1 / data rate 250000 baud 8N2
  localparam logic LINE_BREAK = 1'b0;
  localparam logic LINE_DATA  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_POLL        = 2'd0,
    CMD_SET_CHANNEL = 2'd1,
    CMD_SET_COLOR   = 2'd2
  } cmd_code_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [ELAPSED_W-1:0] elapsed_us;
    logic [SPACE_W-1:0]   tx_space;
    logic [NUM_W-1:0]     slot_number;
    logic [LEVEL_W-1:0]   level;
    logic [BYTE_W-1:0]    red;
    logic [BYTE_W-1:0]    green;
    logic [BYTE_W-1:0]    blue;
  } item_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_item;
    logic timer_add;
    logic timer_clear;
    logic slot_clear;
    logic wr_chan;
    logic wr_color;
    logic run_start;
    logic run_step;
    logic out_break;
    logic out_start;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    cmd_code_t command;
    logic      chan_ok;
    logic      color_ok;
    logic      color_last;
    logic      timer_lt_break;
    logic      timer_ge_limit;
    logic      avail_zero;
    logic      run_last;
    logic      slot_end;
    logic      out_free;
  } dp_status_t;

endpackage

FILE: rtl/dmx512_universe_transmitter.sv
// DMX512 universe transmitter, top level: stream ports, controller and datapath.
// Depends on dmxut_pkg, dmxut_ctrl and dmxut_dp.
`timescale 1ns / 1ps

// Holds the levels of one DMX universe (dmxut_pkg::SLOT_COUNT slots, all zero
// after reset) and paces the frame sequence toward a byte-wide serial
// transmitter. Each input request carries a command in s_tuser: set one
// channel (1-based number, level clamped to 255; zero or out-of-range numbers
// are dropped), set a color triple (fixture n writes slots 3n-3..3n-1, dropped
// whole if it would run past the last slot), or poll. A poll adds elapsed_us
// to a saturating timer and then advances the frame: from idle it sends a zero
// break byte at break line mode; after break_time_us it sends the start code
// at data line mode; then each poll sends as many slot bytes as tx_space allows
// (at most 16 and the FIFO depth); after the last slot it waits for
// SLOT_COUNT * slot_time_us + tail_time_us before going idle again. Every
// output request carries the byte in m_tdata, the line mode in m_tuser
// (0 break rate 83333 baud 8N1, 1 data rate 250000 baud 8N2) and m_tlast on the
// final byte of each poll. Timing: one item at a time. Set color writes its
// three slots through the single memory write port one per cycle; a poll
// sends its slot bytes one per cycle from the registered memory read while
// the output side does not stall. The output register lets the next request
// be taken while the last byte still waits. The user writes config only
// while idle; the block itself does not enforce this.

module dmx512_universe_transmitter (
  input  logic                                clk,
  input  logic                                rst,
  // Input requests
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [12:0] elapsed_us, [17:13] tx_space, [27:18] slot_number, [43:28] level,
  // [51:44] red, [59:52] green, [67:60] blue, [71:68] zero
  input  logic [dmxut_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [1:0] command
  input  logic [dmxut_pkg::CMD_W-1:0]         s_tuser,
  // Output requests
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] tx_byte
  output logic [dmxut_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // [0] line_mode
  output logic                                m_tuser,
  output logic                                m_tlast,   // last_of_run
  // Configuration writes
  input  logic                                cfg_write,
  input  logic [dmxut_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmxut_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int OFS_ELAPSED = 0;
  localparam int OFS_SPACE   = OFS_ELAPSED + dmxut_pkg::ELAPSED_W;
  localparam int OFS_NUM     = OFS_SPACE + dmxut_pkg::SPACE_W;
  localparam int OFS_LEVEL   = OFS_NUM + dmxut_pkg::NUM_W;
  localparam int OFS_RED     = OFS_LEVEL + dmxut_pkg::LEVEL_W;
  localparam int OFS_GREEN   = OFS_RED + dmxut_pkg::BYTE_W;
  localparam int OFS_BLUE    = OFS_GREEN + dmxut_pkg::BYTE_W;

  dmxut_pkg::item_t      in_item;
  dmxut_pkg::ctrl_cmd_t  cmd;
  dmxut_pkg::dp_status_t st;

  // Unpack the request payload
  always_comb begin
    in_item.command     = s_tuser;
    in_item.elapsed_us  = s_tdata[OFS_ELAPSED +: dmxut_pkg::ELAPSED_W];
    in_item.tx_space    = s_tdata[OFS_SPACE +: dmxut_pkg::SPACE_W];
    in_item.slot_number = s_tdata[OFS_NUM +: dmxut_pkg::NUM_W];
    in_item.level       = s_tdata[OFS_LEVEL +: dmxut_pkg::LEVEL_W];
    in_item.red         = s_tdata[OFS_RED +: dmxut_pkg::BYTE_W];
    in_item.green       = s_tdata[OFS_GREEN +: dmxut_pkg::BYTE_W];
    in_item.blue        = s_tdata[OFS_BLUE +: dmxut_pkg::BYTE_W];
  end

  dmxut_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  dmxut_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTHESIS
  // A byte is never loaded over one the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.run_step || cmd.out_break || cmd.out_start) |-> st.out_free)
    else $error("output register overwritten while held");

  // While a run is only partly delivered, no new request is taken
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("input taken during a slot run");

  // The break byte always stands alone in its poll
  a_break_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == dmxut_pkg::LINE_BREAK)) |-> m_tlast)
    else $error("break byte not marked last");

  // A slot run starts only from a loaded poll, never with nothing to send
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    cmd.run_start |-> (!st.avail_zero && $past(cmd.timer_add)))
    else $error("slot run started without a poll");
`endif

endmodule

FILE: rtl/dmxut_ctrl.sv
// Sequencing controller: item decode, frame phase and byte run sequencing.
// Depends on dmxut_pkg; drives dmxut_dp through ctrl_cmd_t.
`timescale 1ns / 1ps

module dmxut_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  dmxut_pkg::dp_status_t  st,
  output dmxut_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POLL,
    S_SEND,
    S_COLOR
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BREAK,
    PH_DATA,
    PH_WAIT
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (st.command)
          dmxut_pkg::CMD_POLL: begin
            cmd.timer_add = 1'b1;
            state_next    = S_POLL;
          end
          dmxut_pkg::CMD_SET_CHANNEL: begin
            cmd.wr_chan = st.chan_ok;
            state_next  = S_IDLE;
          end
          dmxut_pkg::CMD_SET_COLOR: begin
            if (st.color_ok) begin
              cmd.wr_color = 1'b1;
              state_next   = S_COLOR;
            end else begin
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;  // unused code: no effect
        endcase
      end
      S_POLL: begin
        unique case (phase)
          PH_IDLE: begin
            if (st.out_free) begin
              cmd.out_break   = 1'b1;
              cmd.timer_clear = 1'b1;
              phase_next      = PH_BREAK;
              state_next      = S_IDLE;
            end
          end
          PH_BREAK: begin
            if (st.timer_lt_break) begin
              state_next = S_IDLE;
            end else if (st.out_free) begin
              cmd.out_start   = 1'b1;
              cmd.timer_clear = 1'b1;
              cmd.slot_clear  = 1'b1;
              phase_next      = PH_DATA;
              state_next      = S_IDLE;
            end
          end
          PH_DATA: begin
            if (st.avail_zero) begin
              state_next = S_IDLE;
            end else begin
              cmd.run_start = 1'b1;
              state_next    = S_SEND;
            end
          end
          PH_WAIT: begin
            if (st.timer_ge_limit) phase_next = PH_IDLE;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SEND: begin
        if (st.out_free) begin
          cmd.run_step = 1'b1;
          if (st.run_last) begin
            state_next = S_IDLE;
            if (st.slot_end) phase_next = PH_WAIT;
          end
        end
      end
      S_COLOR: begin
        cmd.wr_color = 1'b1;
        if (st.color_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

FILE: rtl/dmxut_dp.sv
// Datapath: item and config registers, timer, slot memory and output register.
// Depends on dmxut_pkg; commanded by dmxut_ctrl.
`timescale 1ns / 1ps

module dmxut_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  dmxut_pkg::item_t                    in_item,
  input  logic                                cfg_write,
  input  logic [dmxut_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmxut_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  dmxut_pkg::ctrl_cmd_t                cmd,
  output dmxut_pkg::dp_status_t               st,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dmxut_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);

  dmxut_pkg::item_t item;

  logic [dmxut_pkg::BREAK_W-1:0] break_time;
  logic [dmxut_pkg::SLOTT_W-1:0] slot_time;
  logic [dmxut_pkg::TAIL_W-1:0]  tail_time;
  logic [dmxut_pkg::LIMIT_W-1:0] frame_limit;

  logic [dmxut_pkg::TIMER_W-1:0] timer;
  logic [dmxut_pkg::TIMER_W:0]   timer_sum;
  logic [dmxut_pkg::NSLOT_W-1:0] next_slot;
  logic [dmxut_pkg::RUN_W-1:0]   run_left;
  logic [dmxut_pkg::RUN_W-1:0]   avail;
  logic [dmxut_pkg::RUN_W-1:0]   run_len;
  logic [dmxut_pkg::NSLOT_W-1:0] slots_left;
  logic [1:0]                    color_step;

  logic [dmxut_pkg::NUM_W-1:0]   num_m1;
  logic [dmxut_pkg::BASE_W-1:0]  color_base;
  logic [dmxut_pkg::BASE_W-1:0]  color_addr;

  logic [dmxut_pkg::BYTE_W-1:0]  slot_mem [dmxut_pkg::SLOT_COUNT];
  logic [dmxut_pkg::SLOT_COUNT-1:0] slot_valid;
  logic                          wr_en;
  logic [dmxut_pkg::SLOT_W-1:0]  wr_addr;
  logic [dmxut_pkg::BYTE_W-1:0]  wr_data;
  logic                          rd_en;
  logic [dmxut_pkg::SLOT_W-1:0]  rd_addr;
  logic [dmxut_pkg::BYTE_W-1:0]  rd_data;
  logic                          rd_valid;
  logic                          out_load;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
  end

  // Configuration registers; frame wait threshold kept registered
  always_ff @(posedge clk) begin
    if (rst) begin
      break_time <= dmxut_pkg::BREAK_TIME_RST;
      slot_time  <= dmxut_pkg::SLOT_TIME_RST;
      tail_time  <= dmxut_pkg::TAIL_TIME_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dmxut_pkg::REG_BREAK_TIME: break_time <= cfg_data[dmxut_pkg::BREAK_W-1:0];
        dmxut_pkg::REG_SLOT_TIME:  slot_time  <= cfg_data[dmxut_pkg::SLOTT_W-1:0];
        dmxut_pkg::REG_TAIL_TIME:  tail_time  <= cfg_data[dmxut_pkg::TAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    frame_limit <= dmxut_pkg::LIMIT_W'(dmxut_pkg::SLOT_COUNT)
                   * dmxut_pkg::LIMIT_W'(slot_time)
                   + dmxut_pkg::LIMIT_W'(tail_time);
  end

  // Saturating microsecond timer
  assign timer_sum = {1'b0, timer} + (dmxut_pkg::TIMER_W + 1)'(item.elapsed_us);

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else if (cmd.timer_clear) begin
      timer <= '0;
    end else if (cmd.timer_add) begin
      timer <= timer_sum[dmxut_pkg::TIMER_W] ? '1 : timer_sum[dmxut_pkg::TIMER_W-1:0];
    end
  end

  // Run length: min(space, fifo depth, run limit, slots left)
  assign avail = (32'(item.tx_space) > dmxut_pkg::RUN_MAX)
                 ? dmxut_pkg::RUN_W'(dmxut_pkg::RUN_MAX)
                 : dmxut_pkg::RUN_W'(item.tx_space);
  assign slots_left = dmxut_pkg::NSLOT_W'(dmxut_pkg::SLOT_COUNT) - next_slot;
  assign run_len = (32'(slots_left) < 32'(avail)) ? dmxut_pkg::RUN_W'(slots_left) : avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot <= '0;
      run_left  <= '0;
    end else begin
      if (cmd.slot_clear) next_slot <= '0;
      else if (cmd.run_step) next_slot <= next_slot + 1'b1;
      if (cmd.run_start) run_left <= run_len;
      else if (cmd.run_step) run_left <= run_left - 1'b1;
    end
  end

  // Slot writes
  assign num_m1     = item.slot_number - 1'b1;
  assign color_base = {1'b0, num_m1, 1'b0} + dmxut_pkg::BASE_W'(num_m1);
  assign color_addr = color_base + dmxut_pkg::BASE_W'(color_step);

  always_ff @(posedge clk) begin
    if (cmd.load_item) color_step <= '0;
    else if (cmd.wr_color) color_step <= color_step + 1'b1;
  end

  always_comb begin
    wr_en   = cmd.wr_chan | cmd.wr_color;
    wr_addr = color_addr[dmxut_pkg::SLOT_W-1:0];
    case (color_step)
      2'd0:    wr_data = item.red;
      2'd1:    wr_data = item.green;
      default: wr_data = item.blue;
    endcase
    if (cmd.wr_chan) begin
      wr_addr = num_m1[dmxut_pkg::SLOT_W-1:0];
      wr_data = (item.level > dmxut_pkg::LEVEL_W'(dmxut_pkg::LEVEL_MAX))
                ? dmxut_pkg::LEVEL_MAX : item.level[dmxut_pkg::BYTE_W-1:0];
    end
  end

  // Slot memory, one write and one registered read per cycle.
  // Valid bits stand in for the all-zero reset of the array.
  assign rd_en   = cmd.run_start | (cmd.run_step & ~st.run_last);
  assign rd_addr = cmd.run_start ? next_slot[dmxut_pkg::SLOT_W-1:0]
                                 : dmxut_pkg::SLOT_W'(next_slot + 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_en) slot_valid[wr_addr] <= 1'b1;
      if (rd_en) rd_valid <= slot_valid[rd_addr];
    end
  end

  // Output register
  assign out_load = cmd.out_break | cmd.out_start | cmd.run_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_break) begin
      m_tdata <= dmxut_pkg::BREAK_BYTE;
      m_tuser <= dmxut_pkg::LINE_BREAK;
      m_tlast <= 1'b1;
    end else if (cmd.out_start) begin
      m_tdata <= dmxut_pkg::START_CODE;
      m_tuser <= dmxut_pkg::LINE_DATA;
      m_tlast <= 1'b1;
    end else if (cmd.run_step) begin
      m_tdata <= rd_valid ? rd_data : '0;
      m_tuser <= dmxut_pkg::LINE_DATA;
      m_tlast <= st.run_last;
    end
  end

  // Status
  always_comb begin
    st.command        = dmxut_pkg::cmd_code_t'(item.command);
    st.chan_ok        = (item.slot_number != '0)
                        && (32'(item.slot_number) <= dmxut_pkg::SLOT_COUNT);
    st.color_ok       = (item.slot_number != '0)
                        && (32'(color_base) + 2 < dmxut_pkg::SLOT_COUNT);
    st.color_last     = (color_step == 2'd2);
    st.timer_lt_break = (timer < dmxut_pkg::TIMER_W'(break_time));
    st.timer_ge_limit = (dmxut_pkg::LIMIT_W'(timer) >= frame_limit);
    st.avail_zero     = (avail == '0);
    st.run_last       = (run_left == dmxut_pkg::RUN_W'(1));
    st.slot_end       = (32'(next_slot) == dmxut_pkg::SLOT_COUNT - 1);
    st.out_free       = ~m_tvalid | m_tready;
  end

endmodule

FILE: verif/dmxut_checker.sv
// Scoreboard for the DMX512 universe transmitter: tracks register writes, predicts the
// transmitter bytes of every accepted request and compares them as they leave the block.
// Depends on dmxut_pkg.
`timescale 1ns / 1ps

module dmxut_checker
  import dmxut_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // [12:0] elapsed_us, [17:13] tx_space, [27:18] slot_number, [43:28] level,
  // [51:44] red, [59:52] green, [67:60] blue, [71:68] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] command
  input  logic [CMD_W-1:0]       s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] tx_byte
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  // [0] line_mode
  input  logic                   m_tuser,
  input  logic                   m_tlast,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     pending,
  output int                     mismatches,
  output int                     bytes_checked,
  output int                     frames_begun
);

  typedef enum logic [1:0] {
    FRAME_IDLE,
    FRAME_BREAK,
    FRAME_SLOTS,
    FRAME_HOLD
  } frame_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              mode;
    logic              last;
  } line_byte_t;

  line_byte_t        bytes_due[$];
  frame_phase_t      phase;
  int unsigned       slot_ptr;
  int unsigned       timer_us;
  logic [BYTE_W-1:0] levels[SLOT_COUNT];
  logic [BREAK_W-1:0] break_us;
  logic [SLOTT_W-1:0] slot_us;
  logic [TAIL_W-1:0]  tail_us;
  int                fails;
  int                checked;
  int                frames;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic due(input logic [BYTE_W-1:0] value, input logic mode, input logic last);
    line_byte_t b;
    b.value = value;
    b.mode  = mode;
    b.last  = last;
    bytes_due.push_back(b);
  endtask

  // One poll: saturating timer update, then one step of the frame sequence.
  task automatic advance_frame(input logic [ELAPSED_W-1:0] elapsed,
                               input logic [SPACE_W-1:0] space);
    int unsigned sum;
    int unsigned room;
    int unsigned count;
    sum = timer_us + 32'(elapsed);
    timer_us = (sum > 65535) ? 65535 : sum;
    case (phase)
      FRAME_IDLE: begin
        due(BREAK_BYTE, LINE_BREAK, 1'b1);
        timer_us = 0;
        phase = FRAME_BREAK;
        frames++;
      end
      FRAME_BREAK: begin
        if (timer_us >= 32'(break_us)) begin
          due(START_CODE, LINE_DATA, 1'b1);
          timer_us = 0;
          slot_ptr = 0;
          phase = FRAME_SLOTS;
        end
      end
      FRAME_SLOTS: begin
        room = 32'(space);
        if (room > TX_FIFO_DEPTH) room = TX_FIFO_DEPTH;
        if (room > RUN_LIMIT) room = RUN_LIMIT;
        if (room != 0) begin
          count = SLOT_COUNT - slot_ptr;
          if (count > room) count = room;
          for (int i = 0; i < count; i++)
            due(levels[slot_ptr + i], LINE_DATA, i + 1 == count);
          slot_ptr += count;
          if (slot_ptr >= SLOT_COUNT) phase = FRAME_HOLD;
        end
      end
      default: begin
        if (timer_us >= SLOT_COUNT * 32'(slot_us) + 32'(tail_us)) phase = FRAME_IDLE;
      end
    endcase
  endtask

  task automatic check_byte();
    line_byte_t want;
    if (bytes_due.size() == 0) begin
      report_mismatch($sformatf("byte %02h mode %0d last %0d with nothing outstanding",
                                m_tdata, m_tuser, m_tlast));
      return;
    end
    want = bytes_due.pop_front();
    checked++;
    if (m_tdata !== want.value)
      report_mismatch($sformatf("tx_byte %02h, want %02h", m_tdata, want.value));
    if (m_tuser !== want.mode)
      report_mismatch($sformatf("line_mode %0d, want %0d", m_tuser, want.mode));
    if (m_tlast !== want.last)
      report_mismatch($sformatf("last_of_run %0d, want %0d", m_tlast, want.last));
  endtask

  always @(posedge clk) begin
    int unsigned num;
    int unsigned base;
    if (rst) begin
      phase    = FRAME_IDLE;
      slot_ptr = 0;
      timer_us = 0;
      foreach (levels[i]) levels[i] = '0;
      break_us = BREAK_TIME_RST;
      slot_us  = SLOT_TIME_RST;
      tail_us  = TAIL_TIME_RST;
      bytes_due.delete();
      fails   = 0;
      checked = 0;
      frames  = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BREAK_TIME: break_us = cfg_data[BREAK_W-1:0];
          REG_SLOT_TIME:  slot_us  = cfg_data[SLOTT_W-1:0];
          REG_TAIL_TIME:  tail_us  = cfg_data[TAIL_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_byte();
      if (s_tvalid && s_tready) begin
        num = 32'(s_tdata[27:18]);
        case (s_tuser)
          CMD_POLL: advance_frame(s_tdata[12:0], s_tdata[17:13]);
          CMD_SET_CHANNEL: begin
            if (num != 0 && num <= SLOT_COUNT)
              levels[num - 1] = (s_tdata[43:28] > LEVEL_W'(LEVEL_MAX))
                                ? LEVEL_MAX : s_tdata[35:28];
          end
          CMD_SET_COLOR: begin
            base = (num - 1) * 3;
            if (num != 0 && base + 2 < SLOT_COUNT) begin
              levels[base]     = s_tdata[51:44];
              levels[base + 1] = s_tdata[59:52];
              levels[base + 2] = s_tdata[67:60];
            end
          end
          default: ;  // unknown command: nothing happens
        endcase
      end
    end
    // Published as registered copies so the stimulus side never races these.
    pending       <= bytes_due.size();
    mismatches    <= fails;
    bytes_checked <= checked;
    frames_begun  <= frames;
  end

endmodule

FILE: verif/tb_dmx512_universe_transmitter.sv
// Testbench top for the DMX512 universe transmitter: clock, reset, request stimulus,
// register programming, output backpressure and the verdict. Depends on dmxut_pkg,
// dmxut_checker and the block itself.
`timescale 1ns / 1ps

module tb_dmx512_universe_transmitter;
  import dmxut_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  // Longest request is a 16-byte poll plus a sink stall or two.
  localparam int DRAIN_CYCLES = 48;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // [12:0] elapsed_us, [17:13] tx_space, [27:18] slot_number, [43:28] level,
  // [51:44] red, [59:52] green, [67:60] blue, [71:68] zero
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  // [1:0] command
  logic [CMD_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  // [7:0] tx_byte
  logic [OUT_TDATA_W-1:0] m_tdata;
  // [0] line_mode
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int pending;
  int mismatches;
  int bytes_checked;
  int frames_begun;

  logic        calm = 1'b0;   // set for the closing phase: no gaps, no stalls
  int unsigned free_run = 0;  // requests left in a gap-free stretch
  int unsigned stall_left = 0;
  int unsigned open_left = 0; // cycles left in a stall-free stretch
  int          sent = 0;
  int          settings = 1;  // reset values count as the first setting

  always #1 clk = ~clk;

  dmx512_universe_transmitter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dmxut_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .mismatches    (mismatches),
    .bytes_checked (bytes_checked),
    .frames_begun  (frames_begun)
  );

  // Output backpressure: random stalls, broken up by stall-free stretches. A stall
  // starts by dropping m_tready and ends when the count hits 1.
  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      m_tready   <= 1'b1;
    end else if (open_left != 0) begin
      open_left <= open_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(1, 14);
    end else if ($urandom_range(0, 31) == 0) begin
      open_left <= $urandom_range(20, 80);
    end
  end

  // All fields random; the constructors below then set what the command uses,
  // so the don't-care fields still toggle.
  function automatic item_t scatter();
    item_t r;
    r.command     = CMD_POLL;
    r.elapsed_us  = ELAPSED_W'($urandom);
    r.tx_space    = SPACE_W'($urandom);
    r.slot_number = NUM_W'($urandom);
    r.level       = LEVEL_W'($urandom);
    r.red         = BYTE_W'($urandom);
    r.green       = BYTE_W'($urandom);
    r.blue        = BYTE_W'($urandom);
    return r;
  endfunction

  function automatic item_t poll_req(input int unsigned elapsed, input int unsigned space);
    item_t r = scatter();
    r.command    = CMD_POLL;
    r.elapsed_us = ELAPSED_W'(elapsed);
    r.tx_space   = SPACE_W'(space);
    return r;
  endfunction

  function automatic item_t chan_req(input int unsigned num, input int unsigned level);
    item_t r = scatter();
    r.command     = CMD_SET_CHANNEL;
    r.slot_number = NUM_W'(num);
    r.level       = LEVEL_W'(level);
    return r;
  endfunction

  function automatic item_t color_req(input int unsigned num, input logic [7:0] red,
                                      input logic [7:0] green, input logic [7:0] blue);
    item_t r = scatter();
    r.command     = CMD_SET_COLOR;
    r.slot_number = NUM_W'(num);
    r.red         = red;
    r.green       = green;
    r.blue        = blue;
    return r;
  endfunction

  // Mostly polls, so frames keep moving through break, slots and hold; set
  // requests sprinkle new levels in, including mid-frame; a few are junk.
  function automatic item_t random_request();
    int unsigned pick = $urandom_range(0, 99);
    int unsigned elapsed;
    int unsigned space;
    int unsigned num;
    if (pick < 60) begin
      case ($urandom_range(0, 2))
        0:       elapsed = $urandom_range(0, 200);
        1:       elapsed = $urandom_range(0, 2000);
        default: elapsed = $urandom_range(0, 8191);
      endcase
      case ($urandom_range(0, 9))
        0:       space = 0;
        1:       space = $urandom_range(17, 31);   // above the FIFO depth, clamped
        default: space = $urandom_range(1, 16);
      endcase
      return poll_req(elapsed, space);
    end
    if (pick < 78) begin
      case ($urandom_range(0, 9))
        0:       num = 0;
        1:       num = $urandom_range(SLOT_COUNT + 1, 512);
        default: num = $urandom_range(1, SLOT_COUNT);
      endcase
      return chan_req(num, $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 65535));
    end
    if (pick < 96) begin
      case ($urandom_range(0, 9))
        0:       num = 0;
        1:       num = $urandom_range(SLOT_COUNT / 3 + 1, 512);
        default: num = $urandom_range(1, SLOT_COUNT / 3);
      endcase
      return color_req(num, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    end
    begin
      item_t r = scatter();
      r.command = CMD_UNKNOWN;
      return r;
    end
  endfunction

  // Drive one request and hold it until the block takes it. tvalid stays up
  // across back-to-back requests; a random gap drops it first.
  task automatic send_request(input item_t req);
    if (free_run != 0) begin
      free_run--;
    end else if (!calm && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end else if ($urandom_range(0, 15) == 0) begin
      free_run = $urandom_range(8, 30);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, req.blue, req.green, req.red, req.level, req.slot_number,
                 req.tx_space, req.elapsed_us};
    s_tuser  <= req.command;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Quiesce: no more requests, every predicted byte out, then a margin for a
  // set request still in flight (those produce nothing to wait on).
  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Back-to-back writes of all three timing registers; only called when idle.
  task automatic program_timing(input int unsigned brk, input int unsigned slot,
                                input int unsigned tail);
    cfg_write <= 1'b1;
    cfg_index <= REG_BREAK_TIME;
    cfg_data  <= CFG_DATA_W'(brk);
    @(posedge clk);
    cfg_index <= REG_SLOT_TIME;
    cfg_data  <= CFG_DATA_W'(slot);
    @(posedge clk);
    cfg_index <= REG_TAIL_TIME;
    cfg_data  <= CFG_DATA_W'(tail);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset timing (break 150, hold 127 * 44 + 100).
    send_request(chan_req(1, 16'hFFFF));           // level saturates to 255
    send_request(chan_req(SLOT_COUNT, 16'h00A5));  // last slot
    send_request(chan_req(0, 16'h0012));           // channel zero dropped
    send_request(chan_req(SLOT_COUNT + 1, 16'h0033)); // just past the end
    send_request(chan_req(512, 16'h5A5A));         // far past the end
    send_request(color_req(1, 8'h11, 8'h22, 8'h33));
    send_request(color_req(SLOT_COUNT / 3, 8'hFF, 8'h00, 8'h80)); // last fixture that fits
    send_request(color_req(SLOT_COUNT / 3 + 1, 8'hAA, 8'hBB, 8'hCC)); // would overrun
    send_request(color_req(0, 8'h01, 8'h02, 8'h03));
    begin
      item_t junk = scatter();
      junk.command = CMD_UNKNOWN;
      send_request(junk);
    end
    send_request(poll_req(0, 0));        // idle: break byte
    send_request(poll_req(0, 16));       // break wait not over yet
    send_request(poll_req(8191, 0));     // start code
    send_request(poll_req(0, 0));        // no room: nothing
    send_request(poll_req(0, 31));       // oversized space, clamped to 16
    send_request(chan_req(20, 16'h0100)); // write ahead of the send pointer
    send_request(chan_req(2, 16'h0077));  // write behind it, shows up next frame
    send_request(poll_req(13, 1));
    send_request(poll_req(0, 17));
    for (int k = 0; k < 6; k++)
      send_request(poll_req($urandom_range(0, 50), 16));  // rest of the slots
    send_request(poll_req(8191, 16));    // hold time done: back to idle

    // Random part over four timing settings: all zeros, all ones, two random.
    // The last one runs with no gaps and no stalls.
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0:       program_timing(0, 0, 0);
        1:       program_timing(1023, 63, 1023);
        default: program_timing($urandom_range(0, 1023), $urandom_range(0, 63),
                                $urandom_range(0, 1023));
      endcase
      if (p == 3) calm <= 1'b1;
      repeat (88) send_request(random_request());
    end

    settle();
    $display("Sent %0d requests across %0d timing settings; %0d frames begun.",
             sent, settings, frames_begun);
    $display("Compared %0d transmitter bytes, %0d mismatches, %0d still owed.",
             bytes_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
